>>> src/bps_pkg.sv
// Types, codes and reset constants shared by the buzzer pattern sequencer.
package bps_pkg;

  localparam int unsigned TickW  = 32;
  localparam int unsigned DutyW  = 9;
  localparam int unsigned MsW    = 16;
  localparam int unsigned CountW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [DutyW-1:0]  ToneDutyRst      = 9'd250;
  localparam logic [MsW-1:0]    PulseMsRst       = 16'd200;
  localparam logic [MsW-1:0]    PulsePeriodMsRst = 16'd400;
  localparam logic [CountW-1:0] AlarmPulsesRst   = 3'd3;

  typedef enum logic [2:0] {
    OP_POLL  = 3'd0,
    OP_OFF   = 3'd1,
    OP_TONE  = 3'd2,
    OP_TEST  = 3'd3,
    OP_WARN  = 3'd4,
    OP_ALARM = 3'd5
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TONE_DUTY    = 2'd0,
    CFG_PULSE_MS     = 2'd1,
    CFG_PULSE_PERIOD = 2'd2,
    CFG_ALARM_PULSES = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [TickW-1:0] now_ms;
    logic [TickW-1:0] beep_ms;
  } in_item_t;

  typedef struct packed {
    logic [DutyW-1:0]  duty;
    logic [CountW-1:0] alarm_remaining;
  } out_item_t;

  // Wrap-safe "now is at or past deadline": sign of the 32-bit difference.
  function automatic logic reached(input logic [TickW-1:0] now,
                                   input logic [TickW-1:0] deadline);
    logic [TickW-1:0] diff;
    diff = now - deadline;
    return ~diff[TickW-1];
  endfunction

endpackage

>>> src/buzzer_pattern_sequencer.sv
// Buzzer pattern sequencer: command-driven PWM duty and alarm pulse train.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one command
//   item: op, the current millisecond tick now_ms and, for the test beep,
//   beep_ms. Every command yields exactly one result item on the output
//   channel (out_valid_o / out_ready_i / out_item_o): the duty compare value
//   after the command and the alarm pulses still to be started.
//   Deadlines compare by the sign of (now - deadline), so tick wrap is safe.
//   A deadline of zero means no pending off deadline; a computed deadline that wraps to zero
//   leaves the tone on until another command changes it.
//   Throughput: one item per cycle while the result is not stalled. Each item
//   passes the input register, then the state update and result register;
//   while a result is stalled it can wait in the input register.
//   The only work per item is a few 32-bit adds and compares.
//   Stalls: when out_ready_i is low the result register holds and the input
//   register fills; in_ready_o then drops until the result is taken.
//   Reset clears the pipeline, zeroes duty, deadline and alarm state, and
//   loads the register defaults (duty 250, pulse 200 ms, period 400 ms,
//   3 pulses). Configuration writes (cfg_we_i) take effect next cycle; the
//   user must issue them only while the block is idle; it is not enforced.
module buzzer_pattern_sequencer
  import bps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);

  // Configuration registers
  logic [DutyW-1:0]  tone_duty_q;
  logic [MsW-1:0]    pulse_ms_q;
  logic [MsW-1:0]    pulse_period_q;
  logic [CountW-1:0] alarm_pulses_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tone_duty_q    <= ToneDutyRst;
      pulse_ms_q     <= PulseMsRst;
      pulse_period_q <= PulsePeriodMsRst;
      alarm_pulses_q <= AlarmPulsesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TONE_DUTY:    tone_duty_q    <= cfg_wdata_i[DutyW-1:0];
        CFG_PULSE_MS:     pulse_ms_q     <= cfg_wdata_i[MsW-1:0];
        CFG_PULSE_PERIOD: pulse_period_q <= cfg_wdata_i[MsW-1:0];
        CFG_ALARM_PULSES: alarm_pulses_q <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: input register feeds the result register.
  logic     in_valid_q;
  in_item_t in_item_q;
  logic     out_valid_q;
  out_item_t out_item_q;
  logic     out_free;
  logic     s1_fire;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
  end

  // Sequencer state
  logic [TickW-1:0]  off_deadline_q, off_deadline_d;
  logic [CountW-1:0] pulses_left_q, pulses_left_d;
  logic [TickW-1:0]  next_start_q, next_start_d;
  logic [DutyW-1:0]  duty_q, duty_d;

  // Per-command state update
  always_comb begin
    logic [TickW-1:0] now;
    now            = in_item_q.now_ms;
    off_deadline_d = off_deadline_q;
    pulses_left_d  = pulses_left_q;
    next_start_d   = next_start_q;
    duty_d         = duty_q;
    case (in_item_q.op)
      OP_POLL: begin
        // A due alarm pulse starts first, then the off deadline is checked.
        if (pulses_left_q != '0 && reached(now, next_start_q)) begin
          duty_d         = tone_duty_q;
          off_deadline_d = now + TickW'(pulse_ms_q);
          next_start_d   = now + TickW'(pulse_period_q);
          pulses_left_d  = pulses_left_q - CountW'(1);
        end
        if (off_deadline_d != '0 && reached(now, off_deadline_d)) begin
          duty_d         = '0;
          off_deadline_d = '0;
        end
      end
      OP_OFF: begin
        duty_d         = '0;
        off_deadline_d = '0;
        pulses_left_d  = '0;
      end
      OP_TONE: begin
        duty_d = tone_duty_q;
      end
      OP_TEST: begin
        duty_d         = tone_duty_q;
        off_deadline_d = now + in_item_q.beep_ms;
        pulses_left_d  = '0;
      end
      OP_WARN: begin
        duty_d         = tone_duty_q;
        off_deadline_d = now + TickW'(pulse_ms_q);
        pulses_left_d  = '0;
      end
      OP_ALARM: begin
        pulses_left_d = alarm_pulses_q;
        next_start_d  = now;
      end
      default: ; // unused op codes leave the state alone
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_deadline_q <= '0;
      pulses_left_q  <= '0;
      next_start_q   <= '0;
      duty_q         <= '0;
    end else if (s1_fire) begin
      off_deadline_q <= off_deadline_d;
      pulses_left_q  <= pulses_left_d;
      next_start_q   <= next_start_d;
      duty_q         <= duty_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_item_q.duty            <= duty_d;
      out_item_q.alarm_remaining <= pulses_left_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> src/bps_checker.sv
// Port-level checks for the buzzer pattern sequencer, bound to the top level.
module bps_sva
  import bps_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // Input only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without a pending result");

  // After each accepted item, a valid result must be on the output; the check does not tie it to that item.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> ##1 out_valid_o)
    else $error("result missing two cycles after item");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("result changed while stalled");

endmodule

bind buzzer_pattern_sequencer bps_sva u_bps_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);
